// File: hw/rtl/ppr_pkg.sv
package ppr_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_START_PATTERN = 2'd0,
    CFG_START_LENGTH  = 2'd1,
    CFG_END_MARKER    = 2'd2
  } cfg_index_e;

  // Field codes carried with every result.
  typedef enum logic [2:0] {
    FC_TIMESTAMP = 3'd0,
    FC_TYPE      = 3'd1,
    FC_SUBTYPE   = 3'd2,
    FC_LENGTH    = 3'd3,
    FC_DATA      = 3'd4,
    FC_STATUS    = 3'd5
  } field_code_e;

  // Fixed field sizes of the packet header.
  localparam logic [8:0] TYPE_BYTES    = 9'd1;
  localparam logic [8:0] SUBTYPE_BYTES = 9'd3;
  localparam logic [8:0] LENGTH_CHARS  = 9'd2;

  // Start pattern bytes held in the pattern register.
  localparam logic [7:0] PATTERN_BYTES = 8'd4;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 2;

  // Current configuration as seen by the parser.
  typedef struct packed {
    logic [31:0] start_pattern;
    logic [2:0]  start_length;
    logic [6:0]  end_marker;
  } cfg_t;

  // One received byte after classification.
  typedef struct packed {
    logic [6:0] value;
    logic       enc_ok;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  // One result of the parser.
  typedef struct packed {
    field_code_e code;
    logic [6:0]  value;
    logic [7:0]  index;
    logic        last;
    logic        enc_ok;
    logic        csum_ok;
    logic [6:0]  rx_csum;
    logic [6:0]  calc_csum;
    logic [7:0]  data_len;
  } res_t;

endpackage

// File: hw/rtl/ppr_front.sv
// Decodes each raw byte: seven-bit value, parity check and hex digit value.
module ppr_front (
  input  logic                 rx_valid_i,
  output logic                 rx_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 push_o,
  input  logic                 full_i,
  output ppr_pkg::item_t       item_o
);

  logic [6:0] value;

  assign value      = rx_byte_i[6:0];
  assign rx_ready_o = !full_i;
  assign push_o     = rx_valid_i && !full_i;

  // A byte with the top bit set needs odd parity over its low seven bits.
  always_comb begin
    item_o.value   = value;
    item_o.enc_ok  = !rx_byte_i[7] || (^value);
    item_o.is_hex  = 1'b0;
    item_o.hex_val = 4'd0;
    if (value >= 7'h30 && value <= 7'h39) begin
      item_o.is_hex  = 1'b1;
      item_o.hex_val = value[3:0];
    end else if ((value >= 7'h41 && value <= 7'h46) ||
                 (value >= 7'h61 && value <= 7'h66)) begin
      item_o.is_hex  = 1'b1;
      item_o.hex_val = value[3:0] + 4'd9;
    end
  end

endmodule

// File: hw/rtl/ppr_queue.sv
// Small queue of classified bytes between the front and the back.
module ppr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppr_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ppr_pkg::item_t item_o
);

  localparam int unsigned PtrW = (ppr_pkg::QDEPTH > 1) ? $clog2(ppr_pkg::QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(ppr_pkg::QDEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(ppr_pkg::QDEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(ppr_pkg::QDEPTH - 1);

  ppr_pkg::item_t mem_q [ppr_pkg::QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == Depth);
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/ppr_back.sv
// Packet parser: walks the packet phases one byte per cycle unless a held
// result is not taken, and holds the result in an output register.
module ppr_back #(
  parameter int unsigned MAX_START_BYTES = 4,
  parameter int unsigned TIMESTAMP_BYTES = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppr_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           pop_o,
  input  ppr_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ppr_pkg::res_t  res_o
);

  localparam logic [7:0] MaxStart = 8'(MAX_START_BYTES);
  localparam logic [8:0] TsBytes  = 9'(TIMESTAMP_BYTES);

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_TIME  = 8'b0000_0010,
    PH_TYPE  = 8'b0000_0100,
    PH_SUB   = 8'b0000_1000,
    PH_LEN   = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CSUM  = 8'b0100_0000,
    PH_TRAIL = 8'b1000_0000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    pos_q, pos_d;
  logic [7:0]    len_q, len_d;
  logic          stopped_q, stopped_d;
  logic [6:0]    xor_q, xor_d;
  logic          par_q, par_d;
  logic [6:0]    csum_q, csum_d;
  logic          out_valid_q, out_valid_d;
  ppr_pkg::res_t res_q, res_d;

  logic [8:0]  pos_inc;
  logic [7:0]  eff_len;
  logic [6:0]  pat_byte;
  logic        is_field;
  logic [8:0]  fsize;
  ppr_pkg::field_code_e fcode;
  phase_e      fnext;
  logic        flast;
  logic        res_load;

  assign pos_inc     = {1'b0, pos_q} + 9'd1;
  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign flast       = (pos_inc >= fsize);

  // Effective number of start bytes and the expected start byte.
  always_comb begin
    eff_len = {5'd0, cfg_i.start_length};
    if (eff_len == 8'd0) begin
      eff_len = 8'd1;
    end
    if (eff_len > MaxStart) begin
      eff_len = MaxStart;
    end
    pat_byte = 7'd0;
    if (pos_q < ppr_pkg::PATTERN_BYTES) begin
      pat_byte = cfg_i.start_pattern[{pos_q[1:0], 3'b000} +: 7];
    end
  end

  // Field geometry of the current phase.
  always_comb begin
    is_field = 1'b1;
    fsize    = TsBytes;
    fcode    = ppr_pkg::FC_TIMESTAMP;
    fnext    = PH_TYPE;
    unique case (phase_q)
      PH_TIME: begin
        fsize = TsBytes;
      end
      PH_TYPE: begin
        fsize = ppr_pkg::TYPE_BYTES;
        fcode = ppr_pkg::FC_TYPE;
        fnext = PH_SUB;
      end
      PH_SUB: begin
        fsize = ppr_pkg::SUBTYPE_BYTES;
        fcode = ppr_pkg::FC_SUBTYPE;
        fnext = PH_LEN;
      end
      PH_LEN: begin
        fsize = ppr_pkg::LENGTH_CHARS;
        fcode = ppr_pkg::FC_LENGTH;
        fnext = PH_DATA;
      end
      PH_DATA: begin
        fsize = {1'b0, len_q};
        fcode = ppr_pkg::FC_DATA;
        fnext = PH_CSUM;
      end
      default: begin
        is_field = 1'b0;
      end
    endcase
  end

  // Per-byte state update and result generation.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_d     = len_q;
    stopped_d = stopped_q;
    xor_d     = xor_q;
    par_d     = par_q;
    csum_d    = csum_q;
    res_load  = 1'b0;
    res_d     = '0;

    if (pop_o) begin
      if (is_field) begin
        // Length characters accumulate as hex until a non-digit shows up.
        if (phase_q == PH_LEN) begin
          if (!stopped_q && item_i.is_hex) begin
            len_d = {len_q[3:0], item_i.hex_val};
          end else begin
            stopped_d = 1'b1;
          end
        end
        par_d       = par_q & item_i.enc_ok;
        xor_d       = xor_q ^ item_i.value;
        res_load    = 1'b1;
        res_d.code  = fcode;
        res_d.value = item_i.value;
        res_d.index = pos_q;
        res_d.last  = flast;
        if (flast) begin
          pos_d   = 8'd0;
          phase_d = fnext;
          if (phase_q == PH_LEN && len_d == 8'd0) begin
            phase_d = PH_CSUM;
          end
        end else begin
          pos_d = pos_inc[7:0];
        end
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (pos_q >= MaxStart || item_i.value != pat_byte) begin
              pos_d     = 8'd0;
              len_d     = 8'd0;
              stopped_d = 1'b0;
              xor_d     = 7'd0;
              par_d     = 1'b1;
              csum_d    = 7'd0;
            end else begin
              if (pos_q == 8'd0) begin
                len_d     = 8'd0;
                stopped_d = 1'b0;
                par_d     = 1'b1;
                csum_d    = 7'd0;
                xor_d     = item_i.value;
              end else begin
                xor_d = xor_q ^ item_i.value;
              end
              pos_d = pos_inc[7:0];
              if (pos_inc >= {1'b0, eff_len}) begin
                pos_d   = 8'd0;
                phase_d = PH_TIME;
              end
            end
          end
          PH_CSUM: begin
            csum_d  = item_i.value;
            phase_d = PH_TRAIL;
          end
          PH_TRAIL: begin
            // The end marker closes the packet with a status result.
            if (item_i.value == cfg_i.end_marker) begin
              res_load        = 1'b1;
              res_d.code      = ppr_pkg::FC_STATUS;
              res_d.last      = 1'b1;
              res_d.enc_ok    = par_q;
              res_d.csum_ok   = (csum_q == xor_q);
              res_d.rx_csum   = csum_q;
              res_d.calc_csum = xor_q;
              res_d.data_len  = len_q;
              phase_d   = PH_HUNT;
              pos_d     = 8'd0;
              len_d     = 8'd0;
              stopped_d = 1'b0;
              xor_d     = 7'd0;
              par_d     = 1'b1;
              csum_d    = 7'd0;
            end
          end
          default: begin
            phase_d = PH_HUNT;
            pos_d   = 8'd0;
          end
        endcase
      end
    end
  end

  // Output register: loaded on a new result, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      pos_q       <= 8'd0;
      len_q       <= 8'd0;
      stopped_q   <= 1'b0;
      xor_q       <= 7'd0;
      par_q       <= 1'b1;
      csum_q      <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      stopped_q   <= stopped_d;
      xor_q       <= xor_d;
      par_q       <= par_d;
      csum_q      <= csum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

// File: hw/rtl/parity_packet_receive_parser.sv
// Serial packet deframer. Raw bytes enter on the rx request channel at one
// byte per cycle while the queue has room; a field result is registered once
// its byte leaves the queue and stays until taken. Sustained throughput is
// one byte per cycle unless results stall, set by the parse step of the back
// end; a two-entry queue after the byte classifier lets input and output
// stall independently. Start, checksum and trailer bytes produce no result;
// the end marker produces a status result with parity, checksum and length.
// Configuration writes are always ready and should be made while idle.
module parity_packet_receive_parser #(
  parameter int unsigned MAX_START_BYTES = 4,
  parameter int unsigned TIMESTAMP_BYTES = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  field_code_o,
  output logic [6:0]  byte_value_o,
  output logic [7:0]  byte_index_o,
  output logic        field_last_o,
  output logic        encoding_ok_o,
  output logic        checksum_ok_o,
  output logic [6:0]  received_checksum_o,
  output logic [6:0]  computed_checksum_o,
  output logic [7:0]  data_length_o
);

  ppr_pkg::cfg_t  cfg_q;
  ppr_pkg::item_t front_item, queue_item;
  ppr_pkg::res_t  res;
  logic           push, full, queue_valid, pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_pattern <= 32'd0;
      cfg_q.start_length  <= 3'd1;
      cfg_q.end_marker    <= 7'h04;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ppr_pkg::CFG_START_PATTERN: cfg_q.start_pattern <= cfg_data_i;
        ppr_pkg::CFG_START_LENGTH:  cfg_q.start_length  <= cfg_data_i[2:0];
        ppr_pkg::CFG_END_MARKER:    cfg_q.end_marker    <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  ppr_front u_front (
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push),
    .full_i     (full),
    .item_o     (front_item)
  );

  ppr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .item_o  (queue_item)
  );

  ppr_back #(
    .MAX_START_BYTES (MAX_START_BYTES),
    .TIMESTAMP_BYTES (TIMESTAMP_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (queue_valid),
    .pop_o       (pop),
    .item_i      (queue_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign field_code_o        = res.code;
  assign byte_value_o        = res.value;
  assign byte_index_o        = res.index;
  assign field_last_o        = res.last;
  assign encoding_ok_o       = res.enc_ok;
  assign checksum_ok_o       = res.csum_ok;
  assign received_checksum_o = res.rx_csum;
  assign computed_checksum_o = res.calc_csum;
  assign data_length_o       = res.data_len;

endmodule

// File: hw/rtl/ppr_checker.sv
// Port-level checks of the deframer results.
module ppr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  field_code_o,
  input logic [6:0]  byte_value_o,
  input logic [7:0]  byte_index_o,
  input logic        field_last_o,
  input logic        encoding_ok_o,
  input logic        checksum_ok_o,
  input logic [6:0]  received_checksum_o,
  input logic [6:0]  computed_checksum_o,
  input logic [7:0]  data_length_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_code_o) &&
    $stable(byte_value_o) && $stable(byte_index_o) && $stable(computed_checksum_o))
    else $error("stalled result changed");

  // A status result is a single last item with no byte value or index.
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_code_o == ppr_pkg::FC_STATUS |->
    field_last_o && byte_value_o == 7'd0 && byte_index_o == 8'd0)
    else $error("malformed status result");

  // Checksum verdict agrees with the two checksums shown.
  a_status_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_code_o == ppr_pkg::FC_STATUS |->
    checksum_ok_o == (received_checksum_o == computed_checksum_o))
    else $error("checksum verdict mismatch");

  // Field results carry no status information.
  a_field_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_code_o != ppr_pkg::FC_STATUS |->
    !encoding_ok_o && !checksum_ok_o && received_checksum_o == 7'd0 &&
    computed_checksum_o == 7'd0 && data_length_o == 8'd0)
    else $error("status bits set on field result");

  // Only the defined field codes appear.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_code_o <= ppr_pkg::FC_STATUS)
    else $error("undefined field code");

endmodule

bind parity_packet_receive_parser ppr_checker u_ppr_checker (.*);
